// ----- rtl/paged_frame_slot_allocator_core_defines.svh -----
// assertion macros used by the checker file of the slot allocator
`ifndef PAGED_FRAME_SLOT_ALLOCATOR_CORE_DEFINES_SVH
`define PAGED_FRAME_SLOT_ALLOCATOR_CORE_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define PFSA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define PFSA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/pfsa_pkg.sv -----
// shared types and constants of the paged slot allocator
package pfsa_pkg;

	localparam int CAP_W = 20;
	localparam int CNT_W = 24;
	localparam int PAGE_OUT_W = 4;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_INITIAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAXIMUM = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BUDGET = 2'd2;

	localparam logic [CAP_W-1:0] RST_INITIAL = 20'd1024;
	localparam logic [CAP_W-1:0] RST_MAXIMUM = 20'd65536;
	localparam logic [CNT_W-1:0] RST_BUDGET = 24'd1048576;

	localparam logic CMD_RESERVE = 1'b0;
	localparam logic CMD_RESET = 1'b1;

	typedef enum logic [1:0] {
		STAT_OK = 2'd0,
		STAT_INVAL = 2'd1,
		STAT_OOM = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		RES_OK,
		RES_INVAL,
		RES_OOM,
		RES_RESET
	} res_kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_CUR_EV,
		ST_SCAN_RD,
		ST_SCAN_EV,
		ST_ROOM,
		ST_GROW,
		ST_CREATE,
		ST_GRANT,
		ST_RST_RD,
		ST_RST_EV,
		ST_RST_FIN
	} ctrl_state_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic latch;
		logic rd_cur;
		logic save_cur_cap;
		logic take_cur;
		logic take_idx;
		logic scan_init;
		logic scan_dec;
		logic cap_init;
		logic cap_grow;
		logic create;
		logic grant;
		logic clr_used;
		logic rst_init;
		logic rst_eval;
		logic rst_fin;
		logic res_en;
		res_kind_t res_kind;
	} dp_ctl_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic is_reset;
		logic invalid;
		logic oom_early;
		logic cur_ok;
		logic have_pages;
		logic fits;
		logic idx_zero;
		logic no_room;
		logic cap_short;
	} dp_stat_t;

endpackage

// ----- rtl/paged_frame_slot_allocator_core.sv -----
// top level of the paged frame slot allocator
//
//  channel   handshake             payload
//  request   start / busy          cmd, slot_count
//  result    done (one cycle)      status, page_index, slot_offset, granted_count,
//                                  page_created, created_capacity
//  config    cfg_we                cfg_index, cfg_data
//
// a request is taken when start is high and busy low. it is checked first, and a
// failed check ends it. otherwise the current page is tried when valid, then the
// pages are searched from the newest down, one page table read per search step;
// if none fits, out of memory ends it or a new page is made, its size doubled
// until the request fits. a reset request sweeps every existing page.
// arst_n clears state and loads the register defaults; results cannot stall.
module paged_frame_slot_allocator_core #(
	parameter int MAX_PAGES = 16,
	parameter int HEAP_LIMIT = 1000000
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic                                  cmd,
	input  logic [pfsa_pkg::CNT_W-1:0]            slot_count,
	input  logic                                  cfg_we,
	input  logic [pfsa_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [pfsa_pkg::CNT_W-1:0]            cfg_data,
	output logic                                  done,
	output pfsa_pkg::status_t                     status,
	output logic [pfsa_pkg::PAGE_OUT_W-1:0]       page_index,
	output logic [pfsa_pkg::CAP_W-1:0]            slot_offset,
	output logic [pfsa_pkg::CAP_W-1:0]            granted_count,
	output logic                                  page_created,
	output logic [pfsa_pkg::CAP_W-1:0]            created_capacity
);
	import pfsa_pkg::*;

	dp_ctl_t  ctl;
	dp_stat_t stat;

	pfsa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.ctl    (ctl),
		.busy   (busy)
	);

	pfsa_dp #(
		.MAX_PAGES  (MAX_PAGES),
		.HEAP_LIMIT (HEAP_LIMIT)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctl              (ctl),
		.stat             (stat),
		.cmd              (cmd),
		.slot_count       (slot_count),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.done             (done),
		.status           (status),
		.page_index       (page_index),
		.slot_offset      (slot_offset),
		.granted_count    (granted_count),
		.page_created     (page_created),
		.created_capacity (created_capacity)
	);

endmodule

// ----- rtl/pfsa_ctrl.sv -----
// controller state machine of the paged slot allocator
module pfsa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  pfsa_pkg::dp_stat_t  stat,
	output pfsa_pkg::dp_ctl_t   ctl,
	output logic                busy
);
	import pfsa_pkg::*;

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		ctl = '0;
		ctl.res_kind = RES_OK;
		state_d = state_q;
		busy = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					ctl.latch = 1'b1;
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (stat.is_reset) begin
					ctl.rst_init = 1'b1;
					state_d = stat.have_pages ? ST_RST_RD : ST_RST_FIN;
				end else if (stat.invalid) begin
					ctl.res_en = 1'b1;
					ctl.res_kind = RES_INVAL;
					state_d = ST_IDLE;
				end else if (stat.oom_early) begin
					ctl.res_en = 1'b1;
					ctl.res_kind = RES_OOM;
					state_d = ST_IDLE;
				end else if (stat.cur_ok) begin
					ctl.rd_cur = 1'b1;
					state_d = ST_CUR_EV;
				end else if (stat.have_pages) begin
					ctl.scan_init = 1'b1;
					state_d = ST_SCAN_RD;
				end else begin
					state_d = ST_ROOM;
				end
			end
			ST_CUR_EV: begin
				ctl.save_cur_cap = 1'b1;
				if (stat.fits) begin
					ctl.take_cur = 1'b1;
					state_d = ST_GRANT;
				end else if (stat.have_pages) begin
					ctl.scan_init = 1'b1;
					state_d = ST_SCAN_RD;
				end else begin
					state_d = ST_ROOM;
				end
			end
			ST_SCAN_RD: begin
				state_d = ST_SCAN_EV;
			end
			ST_SCAN_EV: begin
				if (stat.fits) begin
					ctl.take_idx = 1'b1;
					state_d = ST_GRANT;
				end else if (stat.idx_zero) begin
					state_d = ST_ROOM;
				end else begin
					ctl.scan_dec = 1'b1;
					state_d = ST_SCAN_RD;
				end
			end
			ST_ROOM: begin
				if (stat.no_room) begin
					ctl.res_en = 1'b1;
					ctl.res_kind = RES_OOM;
					state_d = ST_IDLE;
				end else begin
					ctl.cap_init = 1'b1;
					state_d = ST_GROW;
				end
			end
			ST_GROW: begin
				if (stat.cap_short) begin
					ctl.cap_grow = 1'b1;
				end else begin
					state_d = ST_CREATE;
				end
			end
			ST_CREATE: begin
				ctl.create = 1'b1;
				state_d = ST_GRANT;
			end
			ST_GRANT: begin
				ctl.grant = 1'b1;
				ctl.res_en = 1'b1;
				ctl.res_kind = RES_OK;
				state_d = ST_IDLE;
			end
			ST_RST_RD: begin
				ctl.clr_used = 1'b1;
				state_d = ST_RST_EV;
			end
			ST_RST_EV: begin
				ctl.rst_eval = 1'b1;
				if (stat.idx_zero) begin
					state_d = ST_RST_FIN;
				end else begin
					ctl.scan_dec = 1'b1;
					state_d = ST_RST_RD;
				end
			end
			ST_RST_FIN: begin
				ctl.rst_fin = 1'b1;
				ctl.res_en = 1'b1;
				ctl.res_kind = RES_RESET;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/pfsa_dp.sv -----
// datapath of the paged slot allocator: page tables, totals, growth and result
module pfsa_dp #(
	parameter int MAX_PAGES = 16,
	parameter int HEAP_LIMIT = 1000000
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  pfsa_pkg::dp_ctl_t                     ctl,
	output pfsa_pkg::dp_stat_t                    stat,
	input  logic                                  cmd,
	input  logic [pfsa_pkg::CNT_W-1:0]            slot_count,
	input  logic                                  cfg_we,
	input  logic [pfsa_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [pfsa_pkg::CNT_W-1:0]            cfg_data,
	output logic                                  done,
	output pfsa_pkg::status_t                     status,
	output logic [pfsa_pkg::PAGE_OUT_W-1:0]       page_index,
	output logic [pfsa_pkg::CAP_W-1:0]            slot_offset,
	output logic [pfsa_pkg::CAP_W-1:0]            granted_count,
	output logic                                  page_created,
	output logic [pfsa_pkg::CAP_W-1:0]            created_capacity
);
	import pfsa_pkg::*;

	localparam int IdxW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam int PcW = $clog2(MAX_PAGES + 1);
	localparam logic [CAP_W-1:0] HeapLim = CAP_W'(HEAP_LIMIT);

	// configuration
	logic [CAP_W-1:0] init_q, max_q;
	logic [CNT_W-1:0] budget_q;

	// allocator state
	logic [CAP_W-1:0] cap_mem_q [MAX_PAGES];
	logic [CAP_W-1:0] used_mem_q [MAX_PAGES];
	logic [PcW-1:0]   pc_q;
	logic [IdxW-1:0]  cur_q;
	logic             cur_valid_q;
	logic [CNT_W-1:0] used_total_q;
	logic [CNT_W-1:0] cap_total_q;

	// per-request working registers
	logic             cmd_q;
	logic [CNT_W-1:0] count_q;
	logic [IdxW-1:0]  idx_q;
	logic [CAP_W-1:0] rd_cap_q, rd_used_q;
	logic [CAP_W-1:0] cur_cap_q;
	logic [CAP_W-1:0] cap_q;
	logic [IdxW-1:0]  page_q;
	logic [CAP_W-1:0] used_take_q;
	logic             created_q;
	logic [CAP_W-1:0] new_cap_q;
	logic [IdxW-1:0]  best_idx_q;
	logic [CAP_W-1:0] best_cap_q;
	logic             best_valid_q;

	logic             done_q;
	status_t          status_q;
	logic [PAGE_OUT_W-1:0] page_index_q;
	logic [CAP_W-1:0] slot_offset_q, granted_q, created_cap_q;
	logic             page_created_q;

	logic [IdxW-1:0]  rd_addr;
	logic [CNT_W-1:0] slots_left, avail;
	logic [CAP_W-1:0] page_room, clip_cap, start_cap;
	logic             used_we;
	logic [IdxW-1:0]  used_waddr;
	logic [CAP_W-1:0] used_wdata;
	logic [IdxW-1:0]  new_idx;

	function automatic logic [CAP_W-1:0] grow(input logic [CAP_W-1:0] cap,
			input logic [CAP_W-1:0] lim);
		return (cap <= (lim >> 1)) ? {cap[CAP_W-2:0], 1'b0} : lim;
	endfunction

	function automatic logic [CNT_W-1:0] sat_sub(input logic [CNT_W-1:0] a,
			input logic [CNT_W-1:0] b);
		return (a > b) ? (a - b) : '0;
	endfunction

	assign rd_addr = ctl.rd_cur ? cur_q : idx_q;
	assign new_idx = IdxW'(pc_q);
	assign slots_left = sat_sub(budget_q, used_total_q);
	assign avail = sat_sub(budget_q, cap_total_q);
	assign page_room = (rd_cap_q > rd_used_q) ? (rd_cap_q - rd_used_q) : '0;
	assign clip_cap = ({{(CNT_W-CAP_W){1'b0}}, cap_q} > avail) ? CAP_W'(avail) : cap_q;

	always_comb begin
		if (stat.cur_ok) begin
			start_cap = (cur_cap_q < max_q) ? grow(cur_cap_q, max_q) : cur_cap_q;
		end else begin
			start_cap = init_q;
		end
	end

	always_comb begin
		stat.is_reset = (cmd_q == CMD_RESET);
		stat.invalid = (count_q == '0) || (init_q == '0) || (init_q > max_q)
			|| (max_q > HeapLim)
			|| ({{(CNT_W-CAP_W){1'b0}}, init_q} > budget_q);
		stat.oom_early = (count_q > {{(CNT_W-CAP_W){1'b0}}, max_q})
			|| (count_q > slots_left);
		stat.cur_ok = cur_valid_q && (PcW'(cur_q) < pc_q);
		stat.have_pages = (pc_q != '0);
		stat.fits = (count_q <= {{(CNT_W-CAP_W){1'b0}}, page_room});
		stat.idx_zero = (idx_q == '0);
		stat.no_room = (count_q > avail) || (pc_q >= PcW'(MAX_PAGES));
		stat.cap_short = ({{(CNT_W-CAP_W){1'b0}}, cap_q} < count_q);
	end

	// used table write: zero during the reset sweep, bump on a grant
	always_comb begin
		used_we = ctl.clr_used || ctl.grant;
		used_waddr = ctl.clr_used ? idx_q : page_q;
		used_wdata = ctl.clr_used ? '0 : (used_take_q + count_q[CAP_W-1:0]);
	end

	always_ff @(posedge clk) begin
		rd_cap_q <= cap_mem_q[rd_addr];
		rd_used_q <= used_mem_q[rd_addr];
		if (ctl.create) begin
			cap_mem_q[new_idx] <= clip_cap;
		end
		if (used_we) begin
			used_mem_q[used_waddr] <= used_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= RST_INITIAL;
			max_q <= RST_MAXIMUM;
			budget_q <= RST_BUDGET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_INITIAL: init_q <= cfg_data[CAP_W-1:0];
				CFG_MAXIMUM: max_q <= cfg_data[CAP_W-1:0];
				CFG_BUDGET: budget_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
			cur_q <= '0;
			cur_valid_q <= 1'b0;
			used_total_q <= '0;
			cap_total_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= ctl.res_en;
			if (ctl.create) begin
				pc_q <= pc_q + PcW'(1);
				cap_total_q <= cap_total_q + {{(CNT_W-CAP_W){1'b0}}, clip_cap};
			end
			if (ctl.grant) begin
				cur_q <= page_q;
				cur_valid_q <= 1'b1;
				used_total_q <= used_total_q + count_q;
			end
			if (ctl.rst_fin) begin
				cur_q <= best_valid_q ? best_idx_q : '0;
				cur_valid_q <= best_valid_q;
				used_total_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			cmd_q <= cmd;
			count_q <= slot_count;
			created_q <= 1'b0;
		end
		if (ctl.scan_init || ctl.rst_init) begin
			idx_q <= IdxW'(pc_q - PcW'(1));
		end else if (ctl.scan_dec) begin
			idx_q <= idx_q - IdxW'(1);
		end
		if (ctl.save_cur_cap) begin
			cur_cap_q <= rd_cap_q;
		end
		if (ctl.cap_init) begin
			cap_q <= start_cap;
		end else if (ctl.cap_grow) begin
			cap_q <= grow(cap_q, max_q);
		end
		if (ctl.take_cur) begin
			page_q <= cur_q;
			used_take_q <= rd_used_q;
		end else if (ctl.take_idx) begin
			page_q <= idx_q;
			used_take_q <= rd_used_q;
		end else if (ctl.create) begin
			page_q <= new_idx;
			used_take_q <= '0;
			created_q <= 1'b1;
			new_cap_q <= clip_cap;
		end
		if (ctl.rst_init) begin
			best_valid_q <= 1'b0;
		end else if (ctl.rst_eval && (!best_valid_q || rd_cap_q > best_cap_q)) begin
			// strict compare keeps the newest page on a tie
			best_valid_q <= 1'b1;
			best_idx_q <= idx_q;
			best_cap_q <= rd_cap_q;
		end
		if (ctl.res_en) begin
			status_q <= STAT_OK;
			page_index_q <= '0;
			slot_offset_q <= '0;
			granted_q <= '0;
			page_created_q <= 1'b0;
			created_cap_q <= '0;
			case (ctl.res_kind)
				RES_OK: begin
					page_index_q <= PAGE_OUT_W'(page_q);
					slot_offset_q <= used_take_q;
					granted_q <= count_q[CAP_W-1:0];
					page_created_q <= created_q;
					created_cap_q <= created_q ? new_cap_q : '0;
				end
				RES_INVAL: status_q <= STAT_INVAL;
				RES_OOM: status_q <= STAT_OOM;
				default: status_q <= STAT_OK;
			endcase
		end
	end

	assign done = done_q;
	assign status = status_q;
	assign page_index = page_index_q;
	assign slot_offset = slot_offset_q;
	assign granted_count = granted_q;
	assign page_created = page_created_q;
	assign created_capacity = created_cap_q;

endmodule

// ----- rtl/pfsa_checker.sv -----
// port-level checks of the slot allocator and their bind
`include "paged_frame_slot_allocator_core_defines.svh"

module pfsa_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic                              done,
	input pfsa_pkg::status_t                 status,
	input logic [pfsa_pkg::CAP_W-1:0]        slot_offset,
	input logic [pfsa_pkg::CAP_W-1:0]        granted_count,
	input logic                              page_created,
	input logic [pfsa_pkg::CAP_W-1:0]        created_capacity
);
	import pfsa_pkg::*;

	`PFSA_ASSERT_NEXT(a_busy_after_req, start && !busy, busy, "request taken but not busy")
	`PFSA_ASSERT_NEXT(a_done_single, done, !done, "result strobe held two cycles")
	`PFSA_ASSERT_SAME(a_fail_zero, done && status != STAT_OK, granted_count == '0 && !page_created && slot_offset == '0, "failed request grants slots")
	`PFSA_ASSERT_SAME(a_new_page_fits, done && page_created, status == STAT_OK && created_capacity != '0 && granted_count <= created_capacity, "new page smaller than grant")

endmodule

bind paged_frame_slot_allocator_core pfsa_checker u_pfsa_checker (.*);
